// ===== rtl/jsg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsg_pkg: shared types and constants of the jittered sample generator
// Field widths, generator constants, status codes and the control structs
// between the sequencer and the shared arithmetic unit.
// ----------------------------------------------------------------------------
package jsg_pkg;

	// default grid side limit
	localparam int MAX_SIDE_DEF = 16;

	// field widths
	localparam int CNT_W   = 9;
	localparam int SIDE_W  = 5;
	localparam int COORD_W = 16;
	localparam int SQ_W    = 10;
	localparam int LCG_W   = 48;
	localparam int MUL_W   = 35;

	// drand48 generator constants
	localparam logic [MUL_W-1:0] LCG_MUL  = 35'h5DEECE66D;
	localparam logic [LCG_W-1:0] LCG_ADD  = 48'h00000000000B;
	localparam logic [LCG_W-1:0] LCG_SEED = 48'h1234ABCD330E;

	// request kinds
	localparam logic REQ_GENERATE = 1'b0;
	localparam logic REQ_FETCH    = 1'b1;

	// result status codes
	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_NOT_SQUARE = 2'd1;
	localparam logic [1:0] STAT_EMPTY      = 2'd2;

	// command to the shared arithmetic unit
	typedef struct packed {
		logic              start;
		logic [SIDE_W-1:0] grid_pos;
		logic [SIDE_W-1:0] side;
	} arith_cmd_t;

	// response from the shared arithmetic unit
	typedef struct packed {
		logic               done;
		logic [COORD_W-1:0] coord;
	} arith_rsp_t;

	// address width for a store of the given depth
	function automatic int addr_w(input int depth);
		int w;
		w = 1;
		while ((1 << w) < depth)
			w = w + 1;
		return w;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/jsg_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsg_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module jsg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                                clk,
	input  wire logic                                we,
	input  wire logic [jsg_pkg::addr_w(DEPTH)-1:0]   waddr,
	input  wire logic [WIDTH-1:0]                    wdata,
	input  wire logic [jsg_pkg::addr_w(DEPTH)-1:0]   raddr,
	output logic      [WIDTH-1:0]                    rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/jsg_arith.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsg_arith: shared draw-and-place unit
// Steps the 48-bit generator with one 16x35 partial product per cycle, then
// divides {cell, r[47:32]} by the grid side one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jsg_arith (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire jsg_pkg::arith_cmd_t cmd,
	output jsg_pkg::arith_rsp_t      rsp
);
	import jsg_pkg::*;

	localparam logic [1:0] P_IDLE = 2'd0;
	localparam logic [1:0] P_MUL  = 2'd1;
	localparam logic [1:0] P_DIV  = 2'd2;

	localparam logic [3:0] MUL_LAST = 4'd2;
	localparam logic [3:0] DIV_LAST = 4'(COORD_W - 1);

	logic [1:0]          phase_q;
	logic [3:0]          step_q;
	logic                done_q;
	logic [LCG_W-1:0]    lcg_q;
	logic [LCG_W-1:0]    acc_q;
	logic [SIDE_W-1:0]   g_q;
	logic [SIDE_W-1:0]   k_q;
	logic [SIDE_W-1:0]   rem_q;
	logic [COORD_W-1:0]  dvd_q;

	logic [15:0]               chunk;
	logic [MUL_W+15:0]         prod;
	logic [LCG_W-1:0]          addend;
	logic [LCG_W-1:0]          acc_sum;
	logic [SIDE_W:0]           sh;
	logic [SIDE_W:0]           sh_sub;
	logic                      ge;
	logic [SIDE_W-1:0]         rem_nxt;

	// partial product of one state chunk, shifted into place
	always_comb begin
		case (step_q[1:0])
			2'd0:    chunk = lcg_q[15:0];
			2'd1:    chunk = lcg_q[31:16];
			default: chunk = lcg_q[47:32];
		endcase
		prod = (MUL_W + 16)'(chunk) * (MUL_W + 16)'(LCG_MUL);
		case (step_q[1:0])
			2'd0:    addend = prod[47:0];
			2'd1:    addend = {prod[31:0], 16'd0};
			default: addend = {prod[15:0], 32'd0};
		endcase
		acc_sum = acc_q + addend;
	end

	// restoring divide step
	always_comb begin
		sh      = {rem_q, dvd_q[COORD_W-1]};
		sh_sub  = sh - {1'b0, k_q};
		ge      = (sh >= {1'b0, k_q});
		rem_nxt = ge ? sh_sub[SIDE_W-1:0] : sh[SIDE_W-1:0];
	end

	// sequencer and generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
			lcg_q   <= LCG_SEED;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				P_IDLE: begin
					if (cmd.start) begin
						phase_q <= P_MUL;
						step_q  <= '0;
					end
				end
				P_MUL: begin
					if (step_q == MUL_LAST) begin
						lcg_q   <= acc_sum;
						phase_q <= P_DIV;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				P_DIV: begin
					step_q <= step_q + 4'd1;
					if (step_q == DIV_LAST) begin
						phase_q <= P_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					phase_q <= P_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (phase_q)
			P_IDLE: begin
				if (cmd.start) begin
					acc_q <= LCG_ADD;
					g_q   <= cmd.grid_pos;
					k_q   <= cmd.side;
				end
			end
			P_MUL: begin
				acc_q <= acc_sum;
				if (step_q == MUL_LAST) begin
					rem_q <= g_q;
					dvd_q <= acc_sum[LCG_W-1:LCG_W-COORD_W];
				end
			end
			P_DIV: begin
				rem_q <= rem_nxt;
				dvd_q <= {dvd_q[COORD_W-2:0], ge};
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign rsp.done  = done_q;
	assign rsp.coord = dvd_q;

endmodule
`default_nettype wire

// ===== rtl/jittered_sample_generator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jittered_sample_generator_unit: jittered stratified sample generator
// Builds a k-by-k grid of jittered samples and plays them back on request.
// ----------------------------------------------------------------------------
// Usage:
//  s_* takes requests: s_tuser selects generate (0) or fetch (1), s_tdata
//  holds the sample count (generate) and the advance flag (fetch).
//  m_* returns one result per request: m_tuser is the status, m_tdata the
//  x and y coordinates as 0.16 fractions (zero unless a fetch succeeds).
//  One request is in work at a time; s_tready drops after each transfer.
//  A fetch passes through the fetch state, which moves the registered RAM
//  read into the output register; a fetch ends before the next is taken.
//  A generate first finds the integer root in the root search state, then
//  checks it in the check state (a failed or zero-count generate answers
//  from there), then fills the grid: every cell takes two draws, x then y,
//  each a generator step built from partial products followed by bit-serial
//  division in the shared unit.
//  Reset empties the store, zeroes the read index and reseeds the
//  generator; no clearing pass is needed. A stalled result waits in the
//  output register, and the next request is taken once it leaves.
// ----------------------------------------------------------------------------
module jittered_sample_generator_unit #(
	parameter int MAX_SIDE = jsg_pkg::MAX_SIDE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [8:0] sample_count, [9] advance
	input  wire logic [0:0]  s_tuser,   // [0] req_type
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,   // [15:0] sample_x, [31:16] sample_y
	output logic      [1:0]  m_tuser    // [1:0] status
);
	import jsg_pkg::*;

	localparam int CELLS = MAX_SIDE * MAX_SIDE;
	localparam int AW    = addr_w(CELLS);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SQRT   = 3'd1;
	localparam logic [2:0] ST_CHECK  = 3'd2;
	localparam logic [2:0] ST_DRAW_X = 3'd3;
	localparam logic [2:0] ST_DRAW_Y = 3'd4;
	localparam logic [2:0] ST_FETCH  = 3'd5;

	logic [2:0]          state_q;
	logic                out_valid_q;
	logic [CNT_W-1:0]    total_q;
	logic [AW-1:0]       rd_idx_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                adv_q;
	logic [SIDE_W-1:0]   k_q;
	logic [SQ_W-1:0]     sq_q;
	logic [SIDE_W-1:0]   gx_q;
	logic [SIDE_W-1:0]   gy_q;
	logic [AW-1:0]       wr_addr_q;
	logic [COORD_W-1:0]  x_q;
	logic [1:0]          out_status_q;
	logic [COORD_W-1:0]  out_x_q;
	logic [COORD_W-1:0]  out_y_q;

	logic                accept;
	logic [SQ_W-1:0]     sq_try;
	logic                sq_fits;
	logic                check_ok;
	logic                last_col;
	logic                last_row;
	logic                finish;
	logic [SIDE_W-1:0]   gx_nxt;
	logic [SIDE_W-1:0]   gy_nxt;
	logic [AW-1:0]       rd_wrap;
	logic                ram_we;
	logic [COORD_W-1:0]  rd_x;
	logic [COORD_W-1:0]  rd_y;
	arith_cmd_t          cmd;
	arith_rsp_t          rsp;

	// input transfer
	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	// root search: next odd step of the square
	assign sq_try   = sq_q + {4'd0, k_q, 1'b1};
	assign sq_fits  = (sq_try <= {1'b0, cnt_q});
	assign check_ok = (sq_q == {1'b0, cnt_q}) && (int'(k_q) <= MAX_SIDE);

	// grid walk, rows outer and columns inner
	assign last_col = (gx_q == k_q - SIDE_W'(1));
	assign last_row = (gy_q == k_q - SIDE_W'(1));
	assign finish   = last_col && last_row;
	assign gx_nxt   = last_col ? '0 : gx_q + SIDE_W'(1);
	assign gy_nxt   = last_col ? gy_q + SIDE_W'(1) : gy_q;

	// read index wraps at the stored count
	assign rd_wrap = ((int'(rd_idx_q) + 1) == int'(total_q)) ? '0 : rd_idx_q + AW'(1);

	assign ram_we = (state_q == ST_DRAW_Y) && rsp.done;

	// commands to the shared unit
	always_comb begin
		cmd.start    = 1'b0;
		cmd.grid_pos = gx_q;
		cmd.side     = k_q;
		case (state_q)
			ST_CHECK: begin
				if (check_ok && (k_q != '0)) begin
					cmd.start    = 1'b1;
					cmd.grid_pos = '0;
				end
			end
			ST_DRAW_X: begin
				if (rsp.done) begin
					cmd.start    = 1'b1;
					cmd.grid_pos = gy_q;
				end
			end
			ST_DRAW_Y: begin
				if (rsp.done && !finish) begin
					cmd.start    = 1'b1;
					cmd.grid_pos = gx_nxt;
				end
			end
			default: begin
				cmd.start = 1'b0;
			end
		endcase
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			total_q     <= '0;
			rd_idx_q    <= '0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser[0] == REQ_GENERATE) begin
							total_q  <= '0;
							rd_idx_q <= '0;
							state_q  <= ST_SQRT;
						end else begin
							state_q <= ST_FETCH;
						end
					end
				end
				ST_SQRT: begin
					if (!sq_fits) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (!check_ok || (k_q == '0)) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						state_q <= ST_DRAW_X;
					end
				end
				ST_DRAW_X: begin
					if (rsp.done) begin
						state_q <= ST_DRAW_Y;
					end
				end
				ST_DRAW_Y: begin
					if (rsp.done) begin
						if (finish) begin
							total_q     <= cnt_q;
							out_valid_q <= 1'b1;
							state_q     <= ST_IDLE;
						end else begin
							state_q <= ST_DRAW_X;
						end
					end
				end
				ST_FETCH: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
					if ((total_q != '0) && adv_q) begin
						rd_idx_q <= rd_wrap;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cnt_q <= s_tdata[CNT_W-1:0];
					adv_q <= s_tdata[CNT_W];
					k_q   <= '0;
					sq_q  <= '0;
				end
			end
			ST_SQRT: begin
				if (sq_fits) begin
					k_q  <= k_q + SIDE_W'(1);
					sq_q <= sq_try;
				end
			end
			ST_CHECK: begin
				gx_q         <= '0;
				gy_q         <= '0;
				wr_addr_q    <= '0;
				out_status_q <= check_ok ? STAT_OK : STAT_NOT_SQUARE;
				out_x_q      <= '0;
				out_y_q      <= '0;
			end
			ST_DRAW_X: begin
				if (rsp.done) begin
					x_q <= rsp.coord;
				end
			end
			ST_DRAW_Y: begin
				if (rsp.done) begin
					gx_q      <= gx_nxt;
					gy_q      <= gy_nxt;
					wr_addr_q <= wr_addr_q + AW'(1);
					if (finish) begin
						out_status_q <= STAT_OK;
						out_x_q      <= '0;
						out_y_q      <= '0;
					end
				end
			end
			ST_FETCH: begin
				if (total_q == '0) begin
					out_status_q <= STAT_EMPTY;
					out_x_q      <= '0;
					out_y_q      <= '0;
				end else begin
					out_status_q <= STAT_OK;
					out_x_q      <= rd_x;
					out_y_q      <= rd_y;
				end
			end
			default: begin
				x_q <= x_q;
			end
		endcase
	end

	// shared draw-and-place unit
	jsg_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	// sample stores
	jsg_ram #(
		.WIDTH (COORD_W),
		.DEPTH (CELLS)
	) u_store_x (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_addr_q),
		.wdata (x_q),
		.raddr (rd_idx_q),
		.rdata (rd_x)
	);

	jsg_ram #(
		.WIDTH (COORD_W),
		.DEPTH (CELLS)
	) u_store_y (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_addr_q),
		.wdata (rsp.coord),
		.raddr (rd_idx_q),
		.rdata (rd_y)
	);

	// output transfer
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_y_q, out_x_q};
	assign m_tuser  = out_status_q;

endmodule
`default_nettype wire

// ===== rtl/jsg_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsg_checker: port-level checks of the jittered sample generator
// Watches both channels and flags broken results or overlapping requests.
// ----------------------------------------------------------------------------
module jsg_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [1:0]  m_tuser
);
	import jsg_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a result with a failure status carries no coordinates
	a_zero_on_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != STAT_OK) |-> (m_tdata == '0))
		else $error("coordinates on a failed result");

	// status stays within its codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == STAT_OK) || (m_tuser == STAT_NOT_SQUARE)
			|| (m_tuser == STAT_EMPTY))
		else $error("unknown status code");

	// one request in work at a time
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another is in work");

endmodule

bind jittered_sample_generator_unit jsg_checker u_jsg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the jittered sample generator
// Sends generate and fetch requests with random gaps. A scoreboard predicts
// the grid from its own copy of the drand48 generator, the store and the
// read index. It compares every returned status and coordinate pair with the
// oldest pending prediction. Result backpressure is random as well.
// ----------------------------------------------------------------------------
module tb_top;
	import jsg_pkg::*;

	localparam int CELL_CNT    = MAX_SIDE_DEF * MAX_SIDE_DEF;
	localparam int RANDOM_REQS = 1850;
	localparam int STALL_LIMIT = 60000;
	localparam int DRAIN_WAIT  = 20;

	// predicts the grid contents and checks every returned result
	class grid_scoreboard;
		typedef struct packed {
			logic [1:0]         status;
			logic [COORD_W-1:0] x;
			logic [COORD_W-1:0] y;
		} sample_t;

		logic [COORD_W-1:0] grid_x [CELL_CNT];
		logic [COORD_W-1:0] grid_y [CELL_CNT];
		int unsigned        filled;
		int unsigned        cursor;
		logic [LCG_W-1:0]   lcg;
		sample_t            awaited [$];
		int                 errors;

		function new();
			filled = 0;
			cursor = 0;
			lcg    = LCG_SEED;
			errors = 0;
		endfunction

		// one drand48 step, kept mod 2^48 by the 48-bit context
		function logic [LCG_W-1:0] draw();
			lcg = lcg * LCG_MUL + LCG_ADD;
			return lcg;
		endfunction

		// floor((pos*2^48 + r) / (side*2^32))
		function logic [COORD_W-1:0] place_coord(int unsigned pos, int unsigned side,
				logic [LCG_W-1:0] r);
			logic [63:0] num;
			logic [63:0] den;
			num = (64'(pos) << 48) + 64'(r);
			den = 64'(side) << 32;
			return COORD_W'(num / den);
		endfunction

		function void note_request(logic req, logic [CNT_W-1:0] cnt, logic adv);
			sample_t          res;
			int unsigned      k;
			logic [LCG_W-1:0] rx;
			logic [LCG_W-1:0] ry;
			res = '0;
			if (req == REQ_GENERATE) begin
				k = 0;
				while ((k + 1) * (k + 1) <= cnt)
					k++;
				filled = 0;
				cursor = 0;
				if (k * k != cnt || k > MAX_SIDE_DEF) begin
					res.status = STAT_NOT_SQUARE;
				end else begin
					// rows outer, columns inner, x drawn before y
					for (int unsigned gy = 0; gy < k; gy++) begin
						for (int unsigned gx = 0; gx < k; gx++) begin
							rx = draw();
							ry = draw();
							grid_x[gy * k + gx] = place_coord(gx, k, rx);
							grid_y[gy * k + gx] = place_coord(gy, k, ry);
						end
					end
					filled = cnt;
				end
			end else if (filled == 0) begin
				res.status = STAT_EMPTY;
			end else begin
				res.status = STAT_OK;
				res.x = grid_x[cursor];
				res.y = grid_y[cursor];
				if (adv)
					cursor = (cursor + 1) % filled;
			end
			awaited = {awaited, res};
		endfunction

		function void check_result(logic [1:0] status, logic [31:0] data);
			sample_t want;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result, status %0d data %h", $time, status, data);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, status);
				errors++;
			end
			if (data[15:0] !== want.x) begin
				$display("%0t: sample_x expected %h actual %h", $time, want.x, data[15:0]);
				errors++;
			end
			if (data[31:16] !== want.y) begin
				$display("%0t: sample_y expected %h actual %h", $time, want.y, data[31:16]);
				errors++;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [8:0] sample_count, [9] advance
	logic [0:0]  s_tuser;   // [0] req_type
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [15:0] sample_x, [31:16] sample_y
	logic [1:0]  m_tuser;   // [1:0] status

	grid_scoreboard sb;
	bit             sender_calm;
	bit             receiver_calm;
	int             sent;
	int             quiet_cycles;

	jittered_sample_generator_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// gap length: mostly none or short, now and then long
	function automatic int idle_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// side of a valid grid, large sides kept rare
	function automatic int pick_side();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 4);
		if (r < 90)
			return $urandom_range(5, 8);
		if (r < 98)
			return $urandom_range(9, 12);
		return $urandom_range(13, MAX_SIDE_DEF);
	endfunction

	// drive one request and hold it until the transfer
	task automatic issue_request(input logic req, input logic [CNT_W-1:0] cnt,
			input logic adv);
		int gap;
		gap = idle_gap(sender_calm);
		if ($urandom_range(0, 99) == 0)
			sender_calm = ~sender_calm;
		@(negedge clk);
		repeat (gap) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = req;
		s_tdata  = {6'b0, adv, cnt};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_request(req, cnt, adv);
		sent++;
	endtask

	task automatic fetch_burst(input int n, input int adv_pct);
		repeat (n)
			issue_request(REQ_FETCH, CNT_W'($urandom_range(0, 256)),
				$urandom_range(0, 99) < adv_pct);
	endtask

	// result side: random backpressure, changed at the falling edge
	initial begin
		int stall_left;
		int span;
		stall_left = 0;
		span = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			span++;
			if (span >= 200 && $urandom_range(0, 3) == 0) begin
				receiver_calm = ~receiver_calm;
				span = 0;
			end
			if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else begin
				m_tready = 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = idle_gap(receiver_calm);
			end
		end
	end

	// result check at the rising edge
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata);
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// stimulus
	initial begin
		int r;
		int k;
		int cnt;
		sb            = new();
		sender_calm   = 1'b0;
		receiver_calm = 1'b0;
		sent          = 0;
		quiet_cycles  = 0;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = REQ_GENERATE;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// fetch on an empty store after reset, with and without advance
		issue_request(REQ_FETCH, 9'd0, 1'b1);
		issue_request(REQ_FETCH, 9'd0, 1'b0);
		// zero count: ok status, store stays empty
		issue_request(REQ_GENERATE, 9'd0, 1'b1);
		issue_request(REQ_FETCH, 9'd0, 1'b1);
		// counts that are not squares
		issue_request(REQ_GENERATE, 9'd2, 1'b0);
		issue_request(REQ_GENERATE, 9'd255, 1'b1);
		issue_request(REQ_FETCH, 9'd255, 1'b1);
		// single cell, index wraps onto itself
		issue_request(REQ_GENERATE, 9'd1, 1'b0);
		issue_request(REQ_FETCH, 9'd0, 1'b0);
		issue_request(REQ_FETCH, 9'd256, 1'b1);
		issue_request(REQ_FETCH, 9'd0, 1'b1);
		// full grid
		issue_request(REQ_GENERATE, 9'd256, 1'b0);
		repeat (3) issue_request(REQ_FETCH, 9'd0, 1'b1);
		issue_request(REQ_FETCH, 9'd0, 1'b0);
		// two by two grid read past its end
		issue_request(REQ_GENERATE, 9'd4, 1'b1);
		repeat (5) issue_request(REQ_FETCH, 9'd0, 1'b1);
		// failed generate empties the store
		issue_request(REQ_GENERATE, 9'd3, 1'b0);
		issue_request(REQ_FETCH, 9'd0, 1'b1);

		// random part, mostly a grid followed by reads
		while (sent < RANDOM_REQS + 24) begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				k = pick_side();
				issue_request(REQ_GENERATE, CNT_W'(k * k), 1'($urandom_range(0, 1)));
				fetch_burst($urandom_range(1, (3 * k * k + 2 < 40) ? 3 * k * k + 2 : 40), 80);
			end else if (r < 85) begin
				do
					cnt = $urandom_range(2, 256);
				while (cnt == 4 || cnt == 9 || cnt == 16 || cnt == 25 || cnt == 36 ||
					cnt == 49 || cnt == 64 || cnt == 81 || cnt == 100 || cnt == 121 ||
					cnt == 144 || cnt == 169 || cnt == 196 || cnt == 225 || cnt == 256);
				issue_request(REQ_GENERATE, CNT_W'(cnt), 1'($urandom_range(0, 1)));
				fetch_burst($urandom_range(0, 3), 50);
			end else if (r < 90) begin
				issue_request(REQ_GENERATE, 9'd0, 1'($urandom_range(0, 1)));
				fetch_burst($urandom_range(1, 3), 50);
			end else begin
				fetch_burst($urandom_range(1, 10), 50);
			end
		end

		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
